/* rtl/core/kpi_pkg.sv */
`default_nettype none

package kpi_pkg;

    // field widths fixed by the item format
    localparam int ACT_W    = 3;
    localparam int MOT_W    = 3;
    localparam int KEY_W    = 4;
    localparam int PART_W   = 4;
    localparam int POS_W    = 24;
    localparam int ROT_W    = 16;
    localparam int FRM_W    = 10;
    localparam int KCNT_W   = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WR_POS    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WR_ROT    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WR_FRAMES = 3'd4;
    localparam logic [ACT_W-1:0] ACT_WR_HEADER = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_ENABLE = 4'd1;

    // rotation wrap, Q3.12 radians
    localparam logic signed [17:0] ROT_PI     = 18'sd12868;
    localparam logic signed [17:0] ROT_TWO_PI = 18'sd25736;

    // non-looping motions stop this many keys before the end
    localparam int SUB_STOP = 2;

    // six lanes: three position, three rotation
    localparam int LANES = 6;
    // |diff * counter| magnitude width
    localparam int DIV_W = 35;

endpackage

`default_nettype wire

/* rtl/core/kpi_if.sv */
`default_nettype none

interface kpi_item_if import kpi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [MOT_W-1:0]         motion;
    logic [KEY_W-1:0]         key;
    logic [PART_W-1:0]        part;
    logic signed [POS_W-1:0]  value_x;
    logic signed [POS_W-1:0]  value_y;
    logic signed [POS_W-1:0]  value_z;
    logic [FRM_W-1:0]         frames;
    logic [KCNT_W-1:0]        key_count;
    logic                     loop_flag;

    modport source (output valid, action, motion, key, part, value_x, value_y, value_z,
                    frames, key_count, loop_flag, input ready);
    modport sink   (input valid, action, motion, key, part, value_x, value_y, value_z,
                    frames, key_count, loop_flag, output ready);
endinterface

interface kpi_result_if import kpi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PART_W-1:0]        out_part;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [ROT_W-1:0]  rot_x;
    logic signed [ROT_W-1:0]  rot_y;
    logic signed [ROT_W-1:0]  rot_z;
    logic                     last;
    logic                     finished;
    logic [KEY_W-1:0]         pose_now;
    logic [FRM_W-1:0]         counter_now;
    logic [MOT_W-1:0]         motion_now;

    modport source (output valid, out_part, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
                    last, finished, pose_now, counter_now, motion_now, input ready);
    modport sink   (input valid, out_part, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
                    last, finished, pose_now, counter_now, motion_now, output ready);
endinterface

interface kpi_cfg_if import kpi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/kpi_ram.sv */
`default_nettype none

module kpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/keyframe_pose_interpolator.sv */
// Write items: taken while idle, no result.
// Start item: per driven part, two key reads, lane steps without a divide, then emit.
// Tick item: next-key wrap by subtraction, then per part the key reads and the
//   35-step restoring divide that runs all six lanes of a part together.
// rst_n (async, low) clears control state, headers and status; key stores keep contents.
`default_nettype none

module keyframe_pose_interpolator import kpi_pkg::*; #(
    parameter int MAX_PARTS   = 16,
    parameter int MAX_MOTIONS = 8,
    parameter int MAX_KEYS    = 16
) (
    input wire logic    clk,
    input wire logic    rst_n,
    kpi_item_if.sink    item,
    kpi_result_if.source result,
    kpi_cfg_if.sink     cfg
);

    // address fields of the key stores
    localparam int MW     = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;
    localparam int KW     = $clog2(MAX_KEYS);
    localparam int PW     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int KEY_AW = MW + KW + PW;
    localparam int FRM_AW = MW + KW;
    // key count store and the wrap arithmetic on it
    localparam int KCW    = $clog2(MAX_KEYS + 1);
    localparam int RW     = (KCW > 5) ? KCW : 5;
    localparam int PLIM   = (MAX_PARTS < 16) ? MAX_PARTS : 16;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,   // takes items and register writes
        S_MOD  = 9'b000000010,   // next key = (pose+1) mod keys, by subtraction
        S_RDB  = 9'b000000100,   // read current key of part
        S_RDN  = 9'b000001000,   // capture base, read next key
        S_DIFF = 9'b000010000,   // lane differences, rotation wrap
        S_MUL  = 9'b000100000,   // diff * counter, one lane a cycle
        S_DIV  = 9'b001000000,   // restoring divide by frames, all lanes
        S_SUM  = 9'b010000000,   // base + quotient, saturate
        S_EMIT = 9'b100000000    // load output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [4:0] part_count_reg;
    logic       update_enable_reg;

    // motion headers
    logic [KCW-1:0] keys_reg  [MAX_MOTIONS];
    logic           loops_reg [MAX_MOTIONS];

    // playback status
    logic [MOT_W-1:0] cur_motion_reg;
    logic [KEY_W-1:0] cur_pose_reg;
    logic [FRM_W-1:0] counter_reg;
    logic             finished_reg;

    // status after the item in flight
    logic [KEY_W-1:0] st_pose_reg;
    logic [FRM_W-1:0] st_counter_reg;
    logic             st_finished_reg;

    // per-item work registers
    logic [RW-1:0]    mod_reg;
    logic [KEY_W-1:0] next_key_reg;
    logic [FRM_W-1:0] frames_reg;
    logic             interp_reg;
    logic             is_tick_reg;
    logic [4:0]       nparts_reg;
    logic [PART_W-1:0] part_reg;
    logic [2:0]       lane_reg;
    logic [5:0]       div_cnt_reg;

    // lanes 0..2 position, 3..5 rotation (sign-extended)
    logic signed [POS_W-1:0] base_reg [LANES];
    logic signed [POS_W:0]   diff_reg [LANES];
    logic [DIV_W-1:0]        mag_reg  [LANES];
    logic [FRM_W-1:0]        rem_reg  [LANES];
    logic                    neg_reg  [LANES];
    logic signed [POS_W-1:0] res_reg  [LANES];

    // output register
    logic                    out_valid_reg;
    logic [PART_W-1:0]       out_part_reg;
    logic signed [POS_W-1:0] out_pos_reg [3];
    logic signed [ROT_W-1:0] out_rot_reg [3];
    logic                    out_last_reg;
    logic                    out_fin_reg;
    logic [KEY_W-1:0]        out_pose_reg;
    logic [FRM_W-1:0]        out_cnt_reg;
    logic [MOT_W-1:0]        out_motion_reg;

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DIV_W+1:0] v);
        logic signed [DIV_W+1:0] hi;
        logic signed [DIV_W+1:0] lo;
        hi = (DIV_W+2)'(24'sh7fffff);
        lo = (DIV_W+2)'(24'sh800000);
        if (v > hi)
            return 24'sh7fffff;
        else if (v < lo)
            return 24'sh800000;
        else
            return v[POS_W-1:0];
    endfunction

    function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [DIV_W+1:0] v);
        logic signed [DIV_W+1:0] hi;
        logic signed [DIV_W+1:0] lo;
        hi = (DIV_W+2)'(16'sh7fff);
        lo = (DIV_W+2)'(16'sh8000);
        if (v > hi)
            return 16'sh7fff;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[ROT_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // handshakes and item decode
    // ---------------------------------------------------------------
    logic in_fire, cfg_fire, emit_load, emit_last;
    logic m_ok, k_ok, p_ok;
    logic [4:0] n_parts;
    logic [KCW-1:0] nk_cur;
    logic [KCW-1:0] kc_sat;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign in_fire    = item.valid && item.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;

    assign m_ok = int'(item.motion) < MAX_MOTIONS;
    assign k_ok = int'(item.key) < MAX_KEYS;
    assign p_ok = int'(item.part) < MAX_PARTS;

    // part count clipped to what the store holds
    assign n_parts = (int'(part_count_reg) > PLIM) ? 5'(PLIM) : part_count_reg;
    assign nk_cur  = keys_reg[MW'(cur_motion_reg)];
    assign kc_sat  = (int'(item.key_count) > MAX_KEYS) ? KCW'(MAX_KEYS)
                                                       : KCW'(item.key_count);

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);
    assign emit_last = (5'(part_reg) + 5'd1 == nparts_reg);

    // ---------------------------------------------------------------
    // key stores: position and rotation per (motion, key, part),
    // frame count per (motion, key)
    // ---------------------------------------------------------------
    logic                  pos_we, rot_we, frm_we;
    logic [KEY_AW-1:0]     key_waddr, key_raddr;
    logic [FRM_AW-1:0]     frm_waddr, frm_raddr;
    logic [3*POS_W-1:0]    pos_wdata, pos_rdata;
    logic [3*ROT_W-1:0]    rot_wdata, rot_rdata;
    logic [FRM_W-1:0]      frm_rdata;
    logic [KEY_W-1:0]      rd_key;

    assign pos_we = in_fire && (item.action == ACT_WR_POS) && m_ok && k_ok && p_ok;
    assign rot_we = in_fire && (item.action == ACT_WR_ROT) && m_ok && k_ok && p_ok;
    assign frm_we = in_fire && (item.action == ACT_WR_FRAMES) && m_ok && k_ok;

    assign key_waddr = {MW'(item.motion), KW'(item.key), PW'(item.part)};
    assign frm_waddr = {MW'(item.motion), KW'(item.key)};

    // second read of a part goes to the next key
    assign rd_key    = (state_reg == S_RDN) ? next_key_reg : cur_pose_reg;
    assign key_raddr = {MW'(cur_motion_reg), KW'(rd_key), PW'(part_reg)};
    assign frm_raddr = {MW'(cur_motion_reg), KW'(cur_pose_reg)};

    assign pos_wdata = {item.value_z, item.value_y, item.value_x};
    assign rot_wdata = {sat_rot((DIV_W+2)'(item.value_z)),
                        sat_rot((DIV_W+2)'(item.value_y)),
                        sat_rot((DIV_W+2)'(item.value_x))};

    kpi_ram #(.WIDTH(3*POS_W), .DEPTH(2**KEY_AW)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (key_waddr),
        .wdata (pos_wdata),
        .raddr (key_raddr),
        .rdata (pos_rdata)
    );

    kpi_ram #(.WIDTH(3*ROT_W), .DEPTH(2**KEY_AW)) u_rot_ram (
        .clk   (clk),
        .we    (rot_we),
        .waddr (key_waddr),
        .wdata (rot_wdata),
        .raddr (key_raddr),
        .rdata (rot_rdata)
    );

    kpi_ram #(.WIDTH(FRM_W), .DEPTH(2**FRM_AW)) u_frm_ram (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (item.frames),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    // ---------------------------------------------------------------
    // status after a tick, from the frame count of the current key
    // ---------------------------------------------------------------
    logic [KEY_W-1:0] tk_pose;
    logic [FRM_W-1:0] tk_counter;
    logic             tk_finished;

    always_comb
    begin
        tk_pose     = cur_pose_reg;
        tk_counter  = counter_reg + 10'd1;
        tk_finished = finished_reg;
        if (counter_reg >= frm_rdata)
        begin
            tk_counter = counter_reg;
            if (loops_reg[MW'(cur_motion_reg)])
            begin
                tk_counter = '0;
                tk_pose    = mod_reg[KEY_W-1:0];
            end
            else if (RW'(cur_pose_reg) + RW'(SUB_STOP) < RW'(nk_cur))
            begin
                tk_counter = '0;
                tk_pose    = cur_pose_reg + 4'd1;
            end
            else
            begin
                tk_finished = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // lane datapath
    // ---------------------------------------------------------------
    logic signed [POS_W:0]   diff_sel;
    logic signed [DIV_W:0]   prod;
    logic signed [17:0]      rot_d  [3];
    logic signed [17:0]      rot_w  [3];
    logic [FRM_W:0]          div_tmp [LANES];
    logic                    div_ge  [LANES];
    logic signed [DIV_W:0]   q_mag  [LANES];
    logic signed [DIV_W:0]   q_val  [LANES];
    logic signed [DIV_W+1:0] sum    [LANES];

    assign diff_sel = diff_reg[lane_reg];
    assign prod     = diff_sel * $signed({1'b0, counter_reg});

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rot_d[c] = 18'(signed'(rot_rdata[c*ROT_W +: ROT_W]))
                     - 18'(base_reg[3+c]);
            // one wrap by a full turn toward [-pi, pi]
            if (rot_d[c] > ROT_PI)
                rot_w[c] = rot_d[c] - ROT_TWO_PI;
            else if (rot_d[c] < -ROT_PI)
                rot_w[c] = rot_d[c] + ROT_TWO_PI;
            else
                rot_w[c] = rot_d[c];
        end
        for (int i = 0; i < LANES; i++)
        begin
            div_tmp[i] = {rem_reg[i], mag_reg[i][DIV_W-1]};
            div_ge[i]  = div_tmp[i] >= {1'b0, frames_reg};
            q_mag[i]   = signed'({1'b0, mag_reg[i]});
            q_val[i]   = neg_reg[i] ? -q_mag[i] : q_mag[i];
            sum[i]     = (DIV_W+2)'(base_reg[i]) + (DIV_W+2)'(q_val[i]);
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.action == ACT_TICK && update_enable_reg && nk_cur != '0)
                        state_next = S_MOD;
                    else if (item.action == ACT_START && m_ok && n_parts != 5'd0)
                        state_next = S_RDB;
                end
            end
            S_MOD:
            begin
                if (mod_reg < RW'(nk_cur))
                    state_next = (nparts_reg == 5'd0) ? S_IDLE : S_RDB;
            end
            S_RDB:  state_next = S_RDN;
            S_RDN:  state_next = S_DIFF;
            S_DIFF: state_next = S_MUL;
            S_MUL:
            begin
                if (int'(lane_reg) == LANES - 1)
                    state_next = interp_reg ? S_DIV : S_SUM;
            end
            S_DIV:
            begin
                if (int'(div_cnt_reg) == DIV_W - 1)
                    state_next = S_SUM;
            end
            S_SUM:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_load)
                    state_next = emit_last ? S_IDLE : S_RDB;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            part_count_reg    <= '0;
            update_enable_reg <= 1'b1;
            for (int i = 0; i < MAX_MOTIONS; i++)
            begin
                keys_reg[i]  <= '0;
                loops_reg[i] <= 1'b0;
            end
            cur_motion_reg <= '0;
            cur_pose_reg   <= '0;
            counter_reg    <= '0;
            finished_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                if (cfg.index == CFG_PART_COUNT)
                    part_count_reg <= cfg.data;
                else if (cfg.index == CFG_UPDATE_ENABLE)
                    update_enable_reg <= cfg.data[0];
            end

            if (in_fire && item.action == ACT_WR_HEADER && m_ok)
            begin
                keys_reg[MW'(item.motion)]  <= kc_sat;
                loops_reg[MW'(item.motion)] <= item.loop_flag;
            end

            // start takes effect at once: the reads use the new motion
            if (in_fire && item.action == ACT_START && m_ok)
            begin
                cur_motion_reg <= item.motion;
                cur_pose_reg   <= '0;
                counter_reg    <= '0;
                finished_reg   <= 1'b0;
            end

            // tick with no parts commits right after the wrap
            if (state_reg == S_MOD && mod_reg < RW'(nk_cur) && nparts_reg == 5'd0)
            begin
                cur_pose_reg <= tk_pose;
                counter_reg  <= tk_counter;
                finished_reg <= tk_finished;
            end

            if (emit_load && emit_last && is_tick_reg)
            begin
                cur_pose_reg <= st_pose_reg;
                counter_reg  <= st_counter_reg;
                finished_reg <= st_finished_reg;
            end

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // work and payload registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                part_reg   <= '0;
                nparts_reg <= n_parts;
                mod_reg    <= RW'(cur_pose_reg) + RW'(1);
                if (in_fire && item.action == ACT_TICK)
                    is_tick_reg <= 1'b1;
                if (in_fire && item.action == ACT_START)
                begin
                    is_tick_reg     <= 1'b0;
                    interp_reg      <= 1'b0;
                    next_key_reg    <= '0;
                    st_pose_reg     <= '0;
                    st_counter_reg  <= '0;
                    st_finished_reg <= 1'b0;
                end
            end
            S_MOD:
            begin
                if (mod_reg >= RW'(nk_cur))
                begin
                    mod_reg <= mod_reg - RW'(nk_cur);
                end
                else
                begin
                    next_key_reg    <= mod_reg[KEY_W-1:0];
                    frames_reg      <= frm_rdata;
                    interp_reg      <= (frm_rdata != '0);
                    st_pose_reg     <= tk_pose;
                    st_counter_reg  <= tk_counter;
                    st_finished_reg <= tk_finished;
                end
            end
            S_RDB:
            begin
            end
            S_RDN:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    base_reg[c]   <= signed'(pos_rdata[c*POS_W +: POS_W]);
                    base_reg[3+c] <= POS_W'(signed'(rot_rdata[c*ROT_W +: ROT_W]));
                end
            end
            S_DIFF:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    diff_reg[c]   <= (POS_W+1)'(signed'(pos_rdata[c*POS_W +: POS_W]))
                                   - (POS_W+1)'(base_reg[c]);
                    diff_reg[3+c] <= (POS_W+1)'(rot_w[c]);
                end
                lane_reg <= '0;
            end
            S_MUL:
            begin
                neg_reg[lane_reg] <= interp_reg && prod[DIV_W];
                if (!interp_reg)
                    mag_reg[lane_reg] <= '0;
                else if (prod[DIV_W])
                    mag_reg[lane_reg] <= DIV_W'(-prod);
                else
                    mag_reg[lane_reg] <= DIV_W'(prod);
                rem_reg[lane_reg] <= '0;
                lane_reg    <= lane_reg + 3'd1;
                div_cnt_reg <= '0;
            end
            S_DIV:
            begin
                // quotient bits shift in from the bottom of the magnitude
                for (int i = 0; i < LANES; i++)
                begin
                    rem_reg[i] <= div_ge[i] ? FRM_W'(div_tmp[i] - {1'b0, frames_reg})
                                            : div_tmp[i][FRM_W-1:0];
                    mag_reg[i] <= {mag_reg[i][DIV_W-2:0], div_ge[i]};
                end
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            S_SUM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    res_reg[c]   <= sat_pos(sum[c]);
                    res_reg[3+c] <= POS_W'(sat_rot(sum[3+c]));
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                    part_reg <= part_reg + 4'd1;
            end
            default:
            begin
            end
        endcase

        if (emit_load)
        begin
            out_part_reg <= part_reg;
            for (int c = 0; c < 3; c++)
            begin
                out_pos_reg[c] <= res_reg[c];
                out_rot_reg[c] <= res_reg[3+c][ROT_W-1:0];
            end
            out_last_reg   <= emit_last;
            out_fin_reg    <= st_finished_reg;
            out_pose_reg   <= st_pose_reg;
            out_cnt_reg    <= st_counter_reg;
            out_motion_reg <= cur_motion_reg;
        end
    end

    // ---------------------------------------------------------------
    // result channel
    // ---------------------------------------------------------------
    assign result.valid       = out_valid_reg;
    assign result.out_part    = out_part_reg;
    assign result.pos_x       = out_pos_reg[0];
    assign result.pos_y       = out_pos_reg[1];
    assign result.pos_z       = out_pos_reg[2];
    assign result.rot_x       = out_rot_reg[0];
    assign result.rot_y       = out_rot_reg[1];
    assign result.rot_z       = out_rot_reg[2];
    assign result.last        = out_last_reg;
    assign result.finished    = out_fin_reg;
    assign result.pose_now    = out_pose_reg;
    assign result.counter_now = out_cnt_reg;
    assign result.motion_now  = out_motion_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load && emit_last |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after last part");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && item.action != ACT_TICK && item.action != ACT_START
        |=> !$rose(out_valid_reg))
        else $error("result raised by a write item");

    a_pose_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cur_pose_reg) < MAX_KEYS)
        else $error("pose index beyond key store");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> interp_reg && frames_reg != '0)
        else $error("divide entered with zero frame count");

endmodule

`default_nettype wire

/* tb/tb_keyframe_pose_interpolator.sv */
`timescale 1ns / 1ps

module tb_keyframe_pose_interpolator;
    import kpi_pkg::*;

    localparam int NMOT  = 8;
    localparam int NKEY  = 16;
    localparam int NPART = 16;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    // a tick can still run after the last expected result has left
    localparam int SETTLE_CYCLES = 900;

    typedef struct {
        logic [ACT_W-1:0]        action;
        logic [MOT_W-1:0]        motion;
        logic [KEY_W-1:0]        key;
        logic [PART_W-1:0]       part;
        logic signed [POS_W-1:0] vx, vy, vz;
        logic [FRM_W-1:0]        frames;
        logic [KCNT_W-1:0]       key_count;
        logic                    loop_flag;
    } anim_item_t;

    typedef struct {
        logic [PART_W-1:0]       part;
        logic signed [POS_W-1:0] px, py, pz;
        logic signed [ROT_W-1:0] rx, ry, rz;
        logic                    last;
        logic                    finished;
        logic [KEY_W-1:0]        pose;
        logic [FRM_W-1:0]        counter;
        logic [MOT_W-1:0]        motion;
    } pose_t;

    // ------------------------------------------------------------------
    // Pose predictor and store of expected part poses
    // ------------------------------------------------------------------
    class pose_scoreboard;
        logic signed [POS_W-1:0] kpos[NMOT][NKEY][NPART][3];
        logic signed [ROT_W-1:0] krot[NMOT][NKEY][NPART][3];
        logic [FRM_W-1:0]        kfrm[NMOT][NKEY];
        bit                      pos_set[NMOT][NKEY][NPART];
        bit                      rot_set[NMOT][NKEY][NPART];
        bit                      frm_set[NMOT][NKEY];
        int unsigned             nkeys[NMOT];
        bit                      loops[NMOT];
        int unsigned             cur_motion, cur_pose, counter;
        bit                      fin;
        int unsigned             part_count;
        bit                      enable;
        pose_t                   pending[$];
        int                      errors;

        function void reset_state();
            foreach (nkeys[m]) begin
                nkeys[m] = 0;
                loops[m] = 0;
            end
            cur_motion = 0;
            cur_pose = 0;
            counter = 0;
            fin = 1;
            part_count = 0;
            enable = 1;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_PART_COUNT)
                part_count = d;
            else if (idx == CFG_UPDATE_ENABLE)
                enable = d[0];
        endfunction

        // keys 0..n-1 of a motion are fully loaded for every part
        function int max_ready(int m);
            int k;
            bit ok;
            k = 0;
            ok = 1;
            while (ok && k < NKEY) begin
                ok = frm_set[m][k];
                for (int p = 0; p < NPART; p++)
                    ok = ok && pos_set[m][k][p] && rot_set[m][k][p];
                if (ok)
                    k++;
            end
            return k;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void emit_poses(int unsigned nxt, int unsigned frm, bit interp);
            int unsigned n;
            pose_t r;
            longint bp, br, dp, dr;
            n = part_count > NPART ? NPART : part_count;
            for (int i = 0; i < n; i++) begin
                r.part = i;
                for (int c = 0; c < 3; c++) begin
                    bp = kpos[cur_motion][cur_pose][i][c];
                    br = krot[cur_motion][cur_pose][i][c];
                    if (interp && frm != 0) begin
                        dp = longint'(kpos[cur_motion][nxt][i][c]) - bp;
                        dr = longint'(krot[cur_motion][nxt][i][c]) - br;
                        // shortest way around the circle, applied once
                        if (dr > ROT_PI)
                            dr -= ROT_TWO_PI;
                        else if (dr < -ROT_PI)
                            dr += ROT_TWO_PI;
                        bp += dp * longint'(counter) / longint'(frm);
                        br += dr * longint'(counter) / longint'(frm);
                    end
                    bp = clamp(bp, POS_W);
                    br = clamp(br, ROT_W);
                    case (c)
                        0: begin r.px = bp; r.rx = br; end
                        1: begin r.py = bp; r.ry = br; end
                        default: begin r.pz = bp; r.rz = br; end
                    endcase
                end
                r.last = (i + 1 == n);
                pending.push_back(r);
            end
        endfunction

        // status fields carry the state after the item
        function void stamp_status(int first);
            for (int i = first; i < pending.size(); i++) begin
                pending[i].finished = fin;
                pending[i].pose     = cur_pose;
                pending[i].counter  = counter;
                pending[i].motion   = cur_motion;
            end
        endfunction

        function void note_item(anim_item_t it);
            int first;
            int unsigned nk, nxt, frm;
            first = pending.size();
            case (it.action)
                ACT_TICK: begin
                    nk = nkeys[cur_motion];
                    if (enable && nk != 0) begin
                        nxt = (cur_pose + 1) % nk;
                        frm = kfrm[cur_motion][cur_pose];
                        emit_poses(nxt, frm, 1);
                        if (counter >= frm) begin
                            if (loops[cur_motion]) begin
                                counter = 0;
                                cur_pose = (cur_pose + 1) % nk;
                            end else if (cur_pose + SUB_STOP < nk) begin
                                counter = 0;
                                cur_pose++;
                            end else
                                fin = 1;
                        end else
                            counter = (counter + 1) % 1024;
                        stamp_status(first);
                    end
                end
                ACT_START: begin
                    cur_motion = it.motion;
                    cur_pose = 0;
                    counter = 0;
                    fin = 0;
                    emit_poses(0, 0, 0);
                    stamp_status(first);
                end
                ACT_WR_POS: begin
                    kpos[it.motion][it.key][it.part][0] = it.vx;
                    kpos[it.motion][it.key][it.part][1] = it.vy;
                    kpos[it.motion][it.key][it.part][2] = it.vz;
                    pos_set[it.motion][it.key][it.part] = 1;
                end
                ACT_WR_ROT: begin
                    krot[it.motion][it.key][it.part][0] = clamp(it.vx, ROT_W);
                    krot[it.motion][it.key][it.part][1] = clamp(it.vy, ROT_W);
                    krot[it.motion][it.key][it.part][2] = clamp(it.vz, ROT_W);
                    rot_set[it.motion][it.key][it.part] = 1;
                end
                ACT_WR_FRAMES: begin
                    kfrm[it.motion][it.key] = it.frames;
                    frm_set[it.motion][it.key] = 1;
                end
                ACT_WR_HEADER: begin
                    nkeys[it.motion] = it.key_count > NKEY ? NKEY : it.key_count;
                    loops[it.motion] = it.loop_flag;
                end
                default: ;
            endcase
        endfunction

        function void compare(string name, longint e, longint a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(pose_t got);
            pose_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pose for part %0d, expected none", $time, got.part);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("out_part", e.part, got.part);
            compare("pos_x", e.px, got.px);
            compare("pos_y", e.py, got.py);
            compare("pos_z", e.pz, got.pz);
            compare("rot_x", e.rx, got.rx);
            compare("rot_y", e.ry, got.ry);
            compare("rot_z", e.rz, got.rz);
            compare("last", e.last, got.last);
            compare("finished", e.finished, got.finished);
            compare("pose_now", e.pose, got.pose);
            compare("counter_now", e.counter, got.counter);
            compare("motion_now", e.motion, got.motion);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #6 clk = ~clk;

    kpi_item_if   item_ch ();
    kpi_result_if res_ch ();
    kpi_cfg_if    cfg_ch ();

    keyframe_pose_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(res_ch),
        .cfg   (cfg_ch)
    );

    pose_scoreboard sb = new();

    bit     no_idle = 0;        // phases with back-to-back traffic on both sides
    int     hold_requests = 0;  // bumped by the stimulus to ask for a long hold-off
    longint cycles = 0;

    initial begin
        item_ch.valid = 1'b0;
        item_ch.action = '0;
        item_ch.motion = '0;
        item_ch.key = '0;
        item_ch.part = '0;
        item_ch.value_x = '0;
        item_ch.value_y = '0;
        item_ch.value_z = '0;
        item_ch.frames = '0;
        item_ch.key_count = '0;
        item_ch.loop_flag = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // Run guard
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check every transfer, then decide ready for the next edge.
    // A fresh stall is drawn per result; a hold-off request overrides it.
    int stall_left = 0;
    int hold_left = 0;
    int hold_served = 0;
    pose_t got;

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.part     = res_ch.out_part;
            got.px       = res_ch.pos_x;
            got.py       = res_ch.pos_y;
            got.pz       = res_ch.pos_z;
            got.rx       = res_ch.rot_x;
            got.ry       = res_ch.rot_y;
            got.rz       = res_ch.rot_z;
            got.last     = res_ch.last;
            got.finished = res_ch.finished;
            got.pose     = res_ch.pose_now;
            got.counter  = res_ch.counter_now;
            got.motion   = res_ch.motion_now;
            sb.check_result(got);
            stall_left = no_idle ? 0 : $urandom_range(0, 10);
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else
            res_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One item transfer. Valid stays high when the next item follows at once.
    task automatic send_item(anim_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.action    <= it.action;
        item_ch.motion    <= it.motion;
        item_ch.key       <= it.key;
        item_ch.part      <= it.part;
        item_ch.value_x   <= it.vx;
        item_ch.value_y   <= it.vy;
        item_ch.value_z   <= it.vz;
        item_ch.frames    <= it.frames;
        item_ch.key_count <= it.key_count;
        item_ch.loop_flag <= it.loop_flag;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Let the block go quiet: every expected pose out, then its tail work.
    task automatic drain();
        @(posedge clk);
        item_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    // Fields not used by an action still carry random bits.
    function automatic anim_item_t noise_item(logic [ACT_W-1:0] act);
        anim_item_t it;
        it.action    = act;
        it.motion    = $urandom;
        it.key       = $urandom;
        it.part      = $urandom;
        it.vx        = $urandom;
        it.vy        = $urandom;
        it.vz        = $urandom;
        it.frames    = $urandom;
        it.key_count = $urandom;
        it.loop_flag = $urandom;
        return it;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_angle();
        // mostly in range so diffs cross pi often; some saturate on write
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32000)) - 16000;
    endfunction

    task automatic send_header(int m, int kc, bit lp);
        anim_item_t it;
        it = noise_item(ACT_WR_HEADER);
        it.motion = m;
        it.key_count = kc;
        it.loop_flag = lp;
        send_item(it);
    endtask

    task automatic send_frames(int m, int k, int f);
        anim_item_t it;
        it = noise_item(ACT_WR_FRAMES);
        it.motion = m;
        it.key = k;
        it.frames = f;
        send_item(it);
    endtask

    task automatic send_cmd(logic [ACT_W-1:0] act, int m);
        anim_item_t it;
        it = noise_item(act);
        it.motion = m;
        send_item(it);
    endtask

    // Fill one key of a motion: frame count plus pose and rotation of every part.
    task automatic load_key(int m, int k, int f);
        anim_item_t it;
        send_frames(m, k, f);
        for (int p = 0; p < NPART; p++) begin
            it = noise_item(ACT_WR_POS);
            it.motion = m;
            it.key = k;
            it.part = p;
            send_item(it);
            it = noise_item(ACT_WR_ROT);
            it.motion = m;
            it.key = k;
            it.part = p;
            it.vx = rand_angle();
            it.vy = rand_angle();
            it.vz = rand_angle();
            send_item(it);
        end
    endtask

    // Random item that keeps every key read on loaded entries.
    function automatic anim_item_t rand_item();
        anim_item_t it;
        int r, m, mr, lo;
        r = $urandom_range(0, 99);
        it = noise_item(ACT_TICK);
        if (r < 50)
            it.action = ACT_TICK;
        else if (r < 58) begin
            if (sb.max_ready(it.motion) >= 1)
                it.action = ACT_START;
        end else if (r < 66) begin
            it.action = ACT_WR_FRAMES;
            if ($urandom_range(0, 5) != 0)
                it.frames = $urandom_range(0, 6);
        end else if (r < 80)
            it.action = ACT_WR_POS;
        else if (r < 92) begin
            it.action = ACT_WR_ROT;
            it.vx = rand_angle();
            it.vy = rand_angle();
            it.vz = rand_angle();
        end else if (r < 97) begin
            m = it.motion;
            mr = sb.max_ready(m);
            // the playing motion is mostly kept from shrinking below its current pose
            lo = (m == sb.cur_motion && $urandom_range(0, 3) != 0) ? sb.cur_pose + 1 : 0;
            if (lo > mr)
                lo = 0;
            it.action = ACT_WR_HEADER;
            if (mr == NKEY && lo == 0)
                it.key_count = $urandom_range(0, 31);
            else
                it.key_count = $urandom_range(lo, mr);
        end else
            it.action = $urandom_range(6, 7);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int sent;
    anim_item_t it;

    initial begin
        sb.reset_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start while no parts are driven: state moves, nothing comes out
        send_cmd(ACT_START, 0);
        drain();
        write_reg(CFG_PART_COUNT, 16);
        write_reg(CFG_UPDATE_ENABLE, 1);

        // motion 0: three keys, looping, short frame counts
        for (int k = 0; k < 3; k++)
            load_key(0, k, k + 1);
        send_header(0, 3, 1);
        // motion 1: four keys, one shot; key 0 long so the counter can overshoot
        load_key(1, 0, 1023);
        for (int k = 1; k < 4; k++)
            load_key(1, k, 2);
        send_header(1, 4, 0);
        // motion 2: key 0 with zero frames, header empty for now
        load_key(2, 0, 0);
        load_key(2, 1, 3);
        send_header(2, 0, 0);
        // motion 7: every key, header above the key store size
        for (int k = 0; k < NKEY; k++)
            load_key(7, k, $urandom_range(0, 2));
        send_header(7, 31, 1);

        // directed play
        send_cmd(ACT_START, 0);
        repeat (8) send_cmd(ACT_TICK, 0);       // wraps through the loop
        send_cmd(ACT_START, 2);
        send_cmd(ACT_TICK, 0);                  // motion without keys
        send_header(2, 2, 0);
        repeat (3) send_cmd(ACT_TICK, 0);       // zero frames, then finish
        send_cmd(ACT_START, 1);
        repeat (5) send_cmd(ACT_TICK, 0);
        send_frames(1, 0, 2);                   // counter now past frames
        repeat (2) send_cmd(ACT_TICK, 0);
        send_cmd(3'd6, 0);
        send_cmd(3'd7, 5);
        send_cmd(ACT_START, 7);
        drain();

        // ticks while updates are off produce nothing
        write_reg(CFG_UPDATE_ENABLE, 0);
        repeat (3) send_cmd(ACT_TICK, 0);
        drain();
        write_reg(CFG_UPDATE_ENABLE, 1);
        write_reg(CFG_PART_COUNT, 31);          // saturates to all parts
        repeat (3) send_cmd(ACT_TICK, 0);

        // results held off long while ticks keep coming: the block backs up
        hold_requests++;
        repeat (12) send_cmd(ACT_TICK, 0);
        drain();

        // random phases, each with its own register setting
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_reg(CFG_PART_COUNT, 1);
                1: write_reg(CFG_PART_COUNT, 0);
                2: write_reg(CFG_PART_COUNT, 16);
                3: write_reg(CFG_UPDATE_ENABLE, 0);
                4: write_reg(CFG_UPDATE_ENABLE, 1);
                default: write_reg(CFG_PART_COUNT, $urandom_range(2, 15));
            endcase
            no_idle = (ph == 2);
            for (int i = 0; i < 30; i++) begin
                it = rand_item();
                if (it.action <= ACT_WR_HEADER)
                    sent++;
                send_item(it);
            end
            drain();
        end
        no_idle = 0;
        while (sent < 160) begin
            it = rand_item();
            if (it.action <= ACT_WR_HEADER)
                sent++;
            send_item(it);
        end
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/kpi_pkg.sv
rtl/core/kpi_if.sv
rtl/core/kpi_ram.sv
rtl/core/keyframe_pose_interpolator.sv
tb/tb_keyframe_pose_interpolator.sv
